/* src/byte_stack_machine_core_top_defines.svh */
// ---------------------------------------------------------------------------
// byte_stack_machine_core_top_defines
// assertion macros shared by the stack machine rtl
// ---------------------------------------------------------------------------
`ifndef BYTE_STACK_MACHINE_CORE_TOP_DEFINES_SVH
`define BYTE_STACK_MACHINE_CORE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define BSM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BSM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bsm_pkg.sv */
// ---------------------------------------------------------------------------
// bsm_pkg
// types, opcodes and status codes of the byte stack machine
// ---------------------------------------------------------------------------
package bsm_pkg;

  localparam int BSM_MEM_DEPTH = 256;
  localparam logic [15:0] BSM_TIME_LIMIT_RST = 16'd500;
  localparam logic [7:0] BSM_RP_RST = 8'hFF;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_INCS = 8'h10;
  localparam logic [7:0] OP_DECS = 8'h11;
  localparam logic [7:0] OP_ADD  = 8'h12;
  localparam logic [7:0] OP_DIV  = 8'h13;
  localparam logic [7:0] OP_AND  = 8'h14;
  localparam logic [7:0] OP_LDAI = 8'h20;
  localparam logic [7:0] OP_LDBI = 8'h21;
  localparam logic [7:0] OP_LDAS = 8'h22;
  localparam logic [7:0] OP_LDBS = 8'h23;
  localparam logic [7:0] OP_STA  = 8'h24;
  localparam logic [7:0] OP_STB  = 8'h25;
  localparam logic [7:0] OP_STF  = 8'h26;
  localparam logic [7:0] OP_JMP  = 8'h30;
  localparam logic [7:0] OP_JEQ  = 8'h31;
  localparam logic [7:0] OP_JNE  = 8'h32;
  localparam logic [7:0] OP_CALL = 8'h40;
  localparam logic [7:0] OP_RET  = 8'h41;
  localparam logic [7:0] OP_PUT  = 8'h42;
  localparam logic [7:0] OP_CMP  = 8'h43;
  localparam logic [7:0] OP_HALT = 8'hFF;

  localparam logic [7:0] FLAG_ZERO = 8'h01;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_LIMIT   = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] code_addr;
    logic [7:0] code_data;
  } bsm_cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       char_valid;
    logic [7:0] char_out;
    logic [7:0] program_counter;
    logic [7:0] executed_opcode;
  } bsm_result_t;

endpackage

/* src/byte_stack_machine_core_top.sv */
// ---------------------------------------------------------------------------
// byte_stack_machine_core_top
// 8-bit stack machine: code and data memories with registered reads
//
// channel  | handshake              | word
// ---------+------------------------+------------------------------
// command  | start, busy            | cmd (bsm_cmd_t)
// result   | done strobe, no stall  | result (bsm_result_t)
// config   | cfg_valid, cfg_ready   | cfg_data (time limit)
//
// load word: result in the cycle after acceptance, next command at once
// step word: fetch op, fetch immediate, data access, execute
// divide: execute hands over to the bit-serial divider state S_DIV
// halted or time limit step: result in the cycle after acceptance
// memories reset through per-entry valid bits, no clearing pass
// ---------------------------------------------------------------------------
`include "byte_stack_machine_core_top_defines.svh"

module byte_stack_machine_core_top
  import bsm_pkg::*;
#(
  parameter int MEM_DEPTH = BSM_MEM_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  bsm_cmd_t    cmd,
  output logic        done,
  output bsm_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OP   = 5'b00010,
    S_IMM  = 5'b00100,
    S_EXEC = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t state;

  logic [7:0]  pc;
  logic [7:0]  cur_instr;
  logic [7:0]  sp;
  logic [7:0]  rp;
  logic [7:0]  reg_a;
  logic [7:0]  reg_b;
  logic [7:0]  zflag;
  logic [15:0] time_count;
  logic [15:0] time_limit;
  logic [7:0]  op;
  logic [7:0]  imm;

  logic [7:0]           code_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] code_vld;
  logic [7:0]           code_rd;
  logic                 code_rd_vld;
  logic [AW-1:0]        code_raddr;
  logic                 code_we;
  logic [7:0]           code_word;

  logic [7:0]           data_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] data_vld;
  logic [7:0]           data_rd;
  logic                 data_rd_vld;
  logic [AW-1:0]        data_raddr;
  logic                 dm_we;
  logic [7:0]           dm_addr;
  logic [7:0]           dm_wdata;
  logic [7:0]           data_word;

  logic [7:0] div_q;
  logic [7:0] div_rem;
  logic [2:0] div_cnt;
  logic [8:0] div_r2;
  logic       div_ge;
  logic [7:0] div_rem_next;
  logic [7:0] div_q_next;

  logic [7:0] n_pc;
  logic [7:0] n_a;
  logic [7:0] n_b;
  logic [7:0] n_sp;
  logic [7:0] n_rp;
  logic [7:0] n_z;
  logic       legal;
  logic [2:0] n_status;
  logic       n_cv;
  logic       two_ticks;
  logic       start_div;
  logic       zset;

  logic [16:0] tc_sum;
  logic [15:0] tc_next;
  logic [1:0]  tc_incr;

  logic       accept;
  logic       idle_done;
  logic [2:0] idle_status;
  logic       done_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  // words answered without running an instruction
  assign idle_done   = (cmd.req_type == REQ_LOAD) || (cur_instr == OP_HALT) ||
                       (time_count >= time_limit);
  assign idle_status = (cmd.req_type == REQ_LOAD) ? ST_OK :
                       (cur_instr == OP_HALT) ? ST_HALT : ST_LIMIT;

  // code memory
  assign code_we    = accept & (cmd.req_type == REQ_LOAD);
  assign code_raddr = (state == S_OP) ? AW'(pc + 8'd1) : pc[AW-1:0];
  assign code_word  = code_rd_vld ? code_rd : OP_HALT;

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[cmd.code_addr[AW-1:0]] <= cmd.code_data;
    end
    code_rd <= code_mem[code_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_vld    <= '0;
      code_rd_vld <= 1'b0;
    end else begin
      if (code_we) begin
        code_vld[cmd.code_addr[AW-1:0]] <= 1'b1;
      end
      code_rd_vld <= code_vld[code_raddr];
    end
  end

  // data memory
  assign data_raddr = (op == OP_RET) ? AW'(rp + 8'd1) : sp[AW-1:0];
  assign data_word  = data_rd_vld ? data_rd : 8'd0;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_addr[AW-1:0]] <= dm_wdata;
    end
    data_rd <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_vld    <= '0;
      data_rd_vld <= 1'b0;
    end else begin
      if (dm_we) begin
        data_vld[dm_addr[AW-1:0]] <= 1'b1;
      end
      data_rd_vld <= data_vld[data_raddr];
    end
  end

  // divider step
  assign div_r2       = {div_rem, div_q[7]};
  assign div_ge       = (div_r2 >= {1'b0, reg_b});
  assign div_rem_next = div_ge ? 8'(div_r2 - {1'b0, reg_b}) : div_r2[7:0];
  assign div_q_next   = {div_q[6:0], div_ge};

  // execute decode
  assign zset = ((zflag & FLAG_ZERO) == FLAG_ZERO);

  always_comb begin
    n_pc      = pc + 8'd1;
    n_a       = reg_a;
    n_b       = reg_b;
    n_sp      = sp;
    n_rp      = rp;
    n_z       = zflag;
    legal     = 1'b1;
    n_status  = ST_OK;
    n_cv      = 1'b0;
    two_ticks = 1'b0;
    start_div = 1'b0;
    dm_we     = 1'b0;
    dm_addr   = sp;
    dm_wdata  = reg_a;
    unique case (op)
      OP_NOP: begin
      end
      OP_INCS: n_sp = sp + 8'd1;
      OP_DECS: n_sp = sp - 8'd1;
      OP_ADD:  n_a = reg_a + reg_b;
      OP_DIV: begin
        if (reg_b == 8'd0) begin
          n_status = ST_DIVZERO;
          legal    = 1'b0;
        end else begin
          start_div = 1'b1;
        end
      end
      OP_AND: n_a = reg_a & reg_b;
      OP_LDAI: begin
        n_a       = imm;
        two_ticks = 1'b1;
        n_pc      = pc + 8'd2;
      end
      OP_LDBI: begin
        n_b       = imm;
        two_ticks = 1'b1;
        n_pc      = pc + 8'd2;
      end
      OP_LDAS: n_a = data_word;
      OP_LDBS: n_b = data_word;
      OP_STA: begin
        dm_we    = (state == S_EXEC);
        dm_wdata = reg_a;
      end
      OP_STB: begin
        dm_we    = (state == S_EXEC);
        dm_wdata = reg_b;
      end
      OP_STF: begin
        dm_we    = (state == S_EXEC);
        dm_wdata = zflag;
      end
      OP_JMP, OP_JEQ, OP_JNE: begin
        n_b       = imm;
        two_ticks = 1'b1;
        if ((op == OP_JMP) || (op == OP_JEQ && zset) || (op == OP_JNE && !zset)) begin
          n_pc = imm;
        end else begin
          n_pc = pc + 8'd2;
        end
      end
      OP_CALL: begin
        dm_we     = (state == S_EXEC);
        dm_addr   = rp;
        dm_wdata  = pc + 8'd2;
        n_rp      = rp - 8'd1;
        two_ticks = 1'b1;
        n_pc      = imm;
      end
      OP_RET: begin
        n_rp = rp + 8'd1;
        n_pc = data_word;
      end
      OP_PUT: n_cv = 1'b1;
      OP_CMP: n_z = (reg_a == reg_b) ? FLAG_ZERO : 8'd0;
      OP_HALT: begin
        n_status = ST_HALT;
        n_pc     = pc;
      end
      default: begin
        n_status = ST_ILLEGAL;
        legal    = 1'b0;
      end
    endcase
  end

  // saturating time count
  assign tc_incr = (state == S_EXEC && two_ticks) ? 2'd2 : 2'd1;
  assign tc_sum  = {1'b0, time_count} + {15'd0, tc_incr};
  assign tc_next = tc_sum[16] ? 16'hFFFF : tc_sum[15:0];

  // result strobe
  assign done_next = (state == S_IDLE && accept && idle_done) ||
                     (state == S_EXEC && !start_div) ||
                     (state == S_DIV && div_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (state == S_OP) begin
      op <= code_word;
    end
    if (state == S_IMM) begin
      imm <= code_word;
    end
    if (state == S_EXEC && start_div) begin
      div_q   <= reg_a;
      div_rem <= 8'd0;
    end else if (state == S_DIV) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= 8'd0;
      cur_instr  <= OP_NOP;
      sp         <= 8'd0;
      rp         <= BSM_RP_RST;
      reg_a      <= 8'd0;
      reg_b      <= 8'd0;
      zflag      <= 8'd0;
      time_count <= 16'd0;
      time_limit <= BSM_TIME_LIMIT_RST;
      div_cnt    <= 3'd0;
      done       <= 1'b0;
      result     <= '0;
    end else begin
      done <= done_next;
      if (cfg_valid && cfg_ready) begin
        time_limit <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (idle_done) begin
              result <= '{status: idle_status, char_valid: 1'b0, char_out: 8'd0,
                          program_counter: pc, executed_opcode: 8'd0};
            end else begin
              state <= S_OP;
            end
          end
        end
        S_OP:  state <= S_IMM;
        S_IMM: state <= S_EXEC;
        S_EXEC: begin
          if (start_div) begin
            div_cnt <= 3'd0;
            state   <= S_DIV;
          end else begin
            state <= S_IDLE;
            result.status          <= n_status;
            result.char_valid      <= n_cv;
            result.char_out        <= n_cv ? reg_a : 8'd0;
            result.executed_opcode <= op;
            if (legal) begin
              pc         <= n_pc;
              reg_a      <= n_a;
              reg_b      <= n_b;
              sp         <= n_sp;
              rp         <= n_rp;
              zflag      <= n_z;
              cur_instr  <= op;
              time_count <= tc_next;
              result.program_counter <= n_pc;
            end else begin
              cur_instr <= OP_HALT;
              result.program_counter <= pc;
            end
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            state      <= S_IDLE;
            reg_a      <= div_q_next;
            reg_b      <= div_rem_next;
            pc         <= pc + 8'd1;
            cur_instr  <= op;
            time_count <= tc_next;
            result.status          <= ST_OK;
            result.char_valid      <= 1'b0;
            result.char_out        <= 8'd0;
            result.program_counter <= pc + 8'd1;
            result.executed_opcode <= op;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BSM_ASSERT_NXT(a_halt_sticks, cur_instr == OP_HALT, cur_instr == OP_HALT, "halt left")
  `BSM_ASSERT_NXT(a_time_mono, 1'b1, time_count >= $past(time_count), "time went back")
  `BSM_ASSERT_IMP(a_dm_we_exec, dm_we, state == S_EXEC, "data write outside exec")
  `BSM_ASSERT_IMP(a_div_nonzero, state == S_DIV, reg_b != 8'd0, "divide by zero in divider")
  `BSM_ASSERT_IMP(a_cfg_idle, cfg_valid && cfg_ready, state == S_IDLE, "config while busy")

endmodule

/* dv/tb_byte_stack_machine_core_top.sv */
// ---------------------------------------------------------------------------
// tb_byte_stack_machine_core_top
// Checks the byte stack machine against a cycle-free model of its programs.
// The stimulus first loads a short boot program and checks the time limit
// at zero, at its reset value and at its maximum. It then loads random
// programs with a subroutine into alternating halves of code memory and
// steps through them, with noise loads among the steps and limit changes between phases.
// The run ends on a halt, an illegal opcode or a divide by zero.
// Each result word is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_byte_stack_machine_core_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  bsm_cmd_t    cmd = '0;
  logic        done;
  bsm_result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // machine state as the checker sees it
  logic [7:0]  prog_mem [256];
  logic [7:0]  stack_mem [256];
  logic [7:0]  m_pc, m_op, m_sp, m_rp, m_a, m_b, m_flag;
  logic [15:0] m_ticks, m_limit;

  bsm_cmd_t    cmd_pending [$];
  bsm_result_t result_q [$];
  logic        cmd_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          err_count = 0;
  int          items_queued = 0;

  logic [7:0]  img_q [$];
  int          jump_fix_q [$];
  int          target_q [$];

  logic [7:0] main_ops [19] = '{OP_NOP, OP_INCS, OP_DECS, OP_ADD, OP_DIV, OP_AND,
                                OP_LDAI, OP_LDBI, OP_LDAS, OP_LDBS, OP_STA, OP_STB,
                                OP_STF, OP_JMP, OP_JEQ, OP_JNE, OP_CALL, OP_PUT, OP_CMP};
  logic [7:0] sub_ops [10] = '{OP_NOP, OP_ADD, OP_DIV, OP_AND, OP_LDAI, OP_LDBI,
                               OP_LDAS, OP_LDBS, OP_PUT, OP_CMP};
  logic [7:0] corner_vals [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

  byte_stack_machine_core_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void bump_time();
    if (m_ticks != 16'hFFFF) m_ticks++;
  endfunction

  function automatic bsm_result_t exec_word(bsm_cmd_t c);
    bsm_result_t r;
    logic [7:0]  at, op, imm, nxt, aft, quo;
    logic        ok, take;
    r = '0;
    if (c.req_type == REQ_LOAD) begin
      prog_mem[c.code_addr] = c.code_data;
    end else if (m_op == OP_HALT) begin
      r.status = ST_HALT;
    end else if (m_ticks >= m_limit) begin
      r.status = ST_LIMIT;
    end else begin
      at = m_pc;
      op = prog_mem[at];
      nxt = at + 8'd1;
      aft = at + 8'd2;
      imm = prog_mem[nxt];
      ok = 1'b1;
      r.executed_opcode = op;
      case (op)
        OP_NOP: m_pc = nxt;
        OP_INCS: begin m_sp = m_sp + 8'd1; m_pc = nxt; end
        OP_DECS: begin m_sp = m_sp - 8'd1; m_pc = nxt; end
        OP_ADD: begin m_a = m_a + m_b; m_pc = nxt; end
        OP_DIV: begin
          if (m_b == 8'd0) begin
            r.status = ST_DIVZERO;
            ok = 1'b0;
          end else begin
            quo = m_a / m_b;
            m_b = m_a % m_b;
            m_a = quo;
            m_pc = nxt;
          end
        end
        OP_AND: begin m_a = m_a & m_b; m_pc = nxt; end
        OP_LDAI: begin m_a = imm; bump_time(); m_pc = aft; end
        OP_LDBI: begin m_b = imm; bump_time(); m_pc = aft; end
        OP_LDAS: begin m_a = stack_mem[m_sp]; m_pc = nxt; end
        OP_LDBS: begin m_b = stack_mem[m_sp]; m_pc = nxt; end
        OP_STA: begin stack_mem[m_sp] = m_a; m_pc = nxt; end
        OP_STB: begin stack_mem[m_sp] = m_b; m_pc = nxt; end
        OP_STF: begin stack_mem[m_sp] = m_flag; m_pc = nxt; end
        OP_JMP, OP_JEQ, OP_JNE: begin
          take = (op == OP_JMP) ||
                 (op == OP_JEQ && (m_flag & FLAG_ZERO) == FLAG_ZERO) ||
                 (op == OP_JNE && (m_flag & FLAG_ZERO) != FLAG_ZERO);
          m_b = imm;
          bump_time();
          m_pc = take ? imm : aft;
        end
        OP_CALL: begin
          stack_mem[m_rp] = aft;
          m_rp = m_rp - 8'd1;
          bump_time();
          m_pc = imm;
        end
        OP_RET: begin
          m_rp = m_rp + 8'd1;
          m_pc = stack_mem[m_rp];
        end
        OP_PUT: begin
          r.char_valid = 1'b1;
          r.char_out = m_a;
          m_pc = nxt;
        end
        OP_CMP: begin
          m_flag = (m_a == m_b) ? FLAG_ZERO : 8'h00;
          m_pc = nxt;
        end
        OP_HALT: begin
          r.status = ST_HALT;
          m_pc = at;
        end
        default: begin
          r.status = ST_ILLEGAL;
          ok = 1'b0;
        end
      endcase
      if (ok) begin
        m_op = op;
        bump_time();
      end else begin
        m_op = OP_HALT;
        m_pc = at;
      end
    end
    r.program_counter = m_pc;
    return r;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // command driver
  always @(negedge clk) begin
    if (!rst && (!start || cmd_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        start <= 1'b1;
        cmd <= cmd_pending.pop_front();
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor and prediction
  always @(posedge clk) begin : monitor
    bsm_result_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          note_error($sformatf("result word with none pending: %h", result));
        end else begin
          want = result_q.pop_front();
          if (result.status !== want.status)
            note_error($sformatf("status: expected %0d got %0d", want.status, result.status));
          if (result.char_valid !== want.char_valid)
            note_error($sformatf("char_valid: expected %0d got %0d",
                                 want.char_valid, result.char_valid));
          if (result.char_out !== want.char_out)
            note_error($sformatf("char_out: expected %h got %h", want.char_out, result.char_out));
          if (result.program_counter !== want.program_counter)
            note_error($sformatf("program_counter: expected %h got %h",
                                 want.program_counter, result.program_counter));
          if (result.executed_opcode !== want.executed_opcode)
            note_error($sformatf("executed_opcode: expected %h got %h",
                                 want.executed_opcode, result.executed_opcode));
        end
      end
      if (cfg_valid && cfg_ready) m_limit = cfg_data;
      if (start && !busy) result_q.push_back(exec_word(cmd));
      cmd_taken <= start && !busy;
    end
  end

  task automatic push_load(input logic [7:0] addr, input logic [7:0] data);
    bsm_cmd_t c;
    c.req_type = REQ_LOAD;
    c.code_addr = addr;
    c.code_data = data;
    cmd_pending.push_back(c);
    items_queued++;
  endtask

  task automatic push_step();
    bsm_cmd_t c;
    c.req_type = REQ_STEP;
    c.code_addr = 8'($urandom_range(0, 255));
    c.code_data = 8'($urandom_range(0, 255));
    cmd_pending.push_back(c);
    items_queued++;
  endtask

  // loads into the unused top of either half, away from both programs and any jump patch
  task automatic push_noise();
    logic [7:0] addr;
    addr = ($urandom_range(0, 1) ? 8'hE1 : 8'h61) + 8'($urandom_range(0, 30));
    push_load(addr, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (cmd_pending.size() != 0 || start || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_time_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic emit_op(input logic [7:0] op, input logic [7:0] sub_addr);
    logic [7:0] v;
    target_q.push_back(img_q.size());
    case (op)
      // divisor loaded right before so it is never zero
      OP_DIV: begin
        img_q.push_back(OP_LDBI);
        img_q.push_back(8'($urandom_range(1, 255)));
        img_q.push_back(OP_DIV);
      end
      OP_LDAI, OP_LDBI: begin
        v = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : corner_vals[$urandom_range(0, 4)];
        img_q.push_back(op);
        img_q.push_back(v);
      end
      OP_JMP, OP_JEQ, OP_JNE: begin
        jump_fix_q.push_back(img_q.size() + 1);
        img_q.push_back(op);
        img_q.push_back(8'h00);
      end
      OP_CALL: begin
        img_q.push_back(op);
        img_q.push_back(sub_addr);
      end
      default: img_q.push_back(op);
    endcase
  endtask

  // main loop at base, subroutine at base + 0x40
  task automatic load_program(input logic [7:0] base);
    int goal, cnt;
    img_q.delete();
    jump_fix_q.delete();
    target_q.delete();
    goal = $urandom_range(4, 59);
    while (img_q.size() < goal) emit_op(main_ops[$urandom_range(0, 18)], base + 8'h40);
    img_q.push_back(OP_JMP);
    img_q.push_back(base);
    foreach (jump_fix_q[i])
      img_q[jump_fix_q[i]] = base + 8'(target_q[$urandom_range(0, target_q.size() - 1)]);
    foreach (img_q[i]) push_load(base + 8'(i), img_q[i]);
    img_q.delete();
    cnt = $urandom_range(1, 8);
    repeat (cnt) emit_op(sub_ops[$urandom_range(0, 9)], 8'h00);
    img_q.push_back(OP_RET);
    foreach (img_q[i]) push_load(base + 8'h40 + 8'(i), img_q[i]);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] boot [12];
    logic [7:0] base, term_op;
    logic       hit;
    int         kind, n, first_item, phase_n;

    foreach (prog_mem[i]) prog_mem[i] = OP_HALT;
    foreach (stack_mem[i]) stack_mem[i] = 8'h00;
    m_pc = 8'h00;
    m_op = OP_NOP;
    m_sp = 8'h00;
    m_rp = BSM_RP_RST;
    m_a = 8'h00;
    m_b = 8'h00;
    m_flag = 8'h00;
    m_ticks = 16'd0;
    m_limit = BSM_TIME_LIMIT_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // boot program: wrap of add and sp, flag store, put, taken jne
    boot = '{OP_LDAI, 8'hFF, OP_LDBI, 8'h01, OP_ADD, OP_DECS, OP_STF, OP_INCS,
             OP_PUT, OP_CMP, OP_JNE, 8'h00};
    push_load(8'hFF, 8'h00);
    foreach (boot[i]) push_load(8'(i), boot[i]);
    repeat (6) push_step();
    wait_idle();
    set_time_limit(16'd0);
    repeat (2) push_step();
    wait_idle();
    set_time_limit(16'hFFFF);
    repeat (4) push_step();

    first_item = items_queued;
    phase_n = 0;
    while (items_queued - first_item < 400) begin
      wait_idle();
      kind = $urandom_range(0, 9);
      n = int'(m_ticks) + $urandom_range(0, 20);
      if (kind == 0) set_time_limit(16'd0);
      else if (kind < 4) set_time_limit(n > 65535 ? 16'hFFFF : 16'(n));
      else if (kind == 4) set_time_limit(16'($urandom_range(0, 65535)));
      else set_time_limit(16'hFFFF);
      if (phase_n == 0 || $urandom_range(0, 2) != 0) begin
        base = (m_pc < 8'h80) ? 8'h80 : 8'h00;
        load_program(base);
        push_load(m_pc, OP_JMP);
        push_load(m_pc + 8'd1, base);
      end
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 7) == 0) push_noise();
        push_step();
      end
      phase_n++;
    end

    // end the program on a halt, a divide by zero or an illegal opcode
    wait_idle();
    set_time_limit(16'hFFFF);
    base = (m_pc < 8'h80) ? 8'h80 : 8'h00;
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      push_load(base, OP_HALT);
    end else if (kind == 1) begin
      push_load(base, OP_LDBI);
      push_load(base + 8'd1, 8'h00);
      push_load(base + 8'd2, OP_DIV);
    end else begin
      do begin
        term_op = 8'($urandom_range(0, 255));
        hit = (term_op == OP_HALT) || (term_op == OP_RET);
        foreach (main_ops[i]) if (main_ops[i] == term_op) hit = 1'b1;
      end while (hit);
      push_load(base, term_op);
    end
    push_load(m_pc, OP_JMP);
    push_load(m_pc + 8'd1, base);
    repeat (5) push_step();
    push_noise();
    wait_idle();
    // halted wins over the time limit
    set_time_limit(16'd0);
    repeat (2) push_step();
    wait_idle();

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
